FILE: design/mnlc_pkg.sv
package mnlc_pkg;

	localparam int TABLE_ENTRIES   = 40;
	localparam int ADMIN_MIN_LEN   = 10;
	localparam int DEFINED_ENTRIES = 40;
	localparam int MATCH_ENTRIES   =
		(TABLE_ENTRIES < DEFINED_ENTRIES) ? TABLE_ENTRIES : DEFINED_ENTRIES;

	localparam logic [7:0]  MIN_FRAME_LEN   = 8'd5;
	localparam logic [7:0]  ADMIN_LEN       = 8'(ADMIN_MIN_LEN);
	localparam logic [31:0] FRAME_MAGIC     = 32'h454E_4F57;  // "ENOW"
	localparam logic [7:0]  TYPE_CORE_REPLY = 8'd2;
	localparam logic [7:0]  TYPE_ADMIN      = 8'd5;
	localparam logic [47:0] BROADCAST_MAC   = 48'hFFFF_FFFF_FFFF;
	localparam logic [7:0]  RANGE_END_RST   = 8'(TABLE_ENTRIES - 1);

	localparam logic [15:0] REQ_INIT_RST    = 16'd300;
	localparam logic [15:0] REQ_MAX_RST     = 16'd5000;
	localparam logic [15:0] HB_PERIOD_RST   = 16'd5000;
	localparam logic [15:0] SCAN_PERIOD_RST = 16'd4500;

	localparam logic [7:0] CHAN_TABLE [DEFINED_ENTRIES] = '{
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
		8'd13, 8'd14, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd60, 8'd64,
		8'd100, 8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd132, 8'd136, 8'd140,
		8'd144, 8'd149, 8'd153, 8'd157, 8'd161, 8'd165, 8'd169, 8'd173, 8'd177
	};

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_FRAME = 2'd1,
		OP_SCAN  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_REQ_INIT    = 2'd0,
		REG_REQ_MAX     = 2'd1,
		REG_HB_PERIOD   = 2'd2,
		REG_SCAN_PERIOD = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ACT_IDLE       = 4'd0,
		ACT_ADOPT      = 4'd1,
		ACT_REQUEST    = 4'd2,
		ACT_HEARTBEAT  = 4'd3,
		ACT_SCAN_START = 4'd4,
		ACT_FORWARD    = 4'd5,
		ACT_FILTERED   = 4'd6,
		ACT_IGNORED    = 4'd7,
		ACT_LATCHED    = 4'd8,
		ACT_ASSIGNED   = 4'd9,
		ACT_UNCHANGED  = 4'd10
	} action_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_ms;
		logic [7:0]  len;
		logic [31:0] magic;
		logic [7:0]  frame_type;
		logic [47:0] src_mac;
		logic [7:0]  version;
		logic [7:0]  start_idx;
		logic [7:0]  end_idx;
		logic [7:0]  scan_ch;
	} item_t;

	typedef struct packed {
		logic [15:0] req_init;
		logic [15:0] req_max;
		logic [15:0] hb_period;
		logic [15:0] scan_period;
	} cfg_t;

	// all results of one item; only action and beat count differ
	typedef struct packed {
		logic [1:0]        cnt;
		action_t [2:0]     act;
		logic [47:0]       dest_mac;
		logic              linked;
		logic [31:0]       beat_old;
		logic [31:0]       beat_new;
		logic [31:0]       found;
		logic [31:0]       sent;
	} grp_t;

	typedef struct packed {
		action_t     action;
		logic [47:0] dest_mac;
		logic [31:0] beat;
		logic        linked;
		logic [31:0] found;
		logic [31:0] sent;
		logic        last;
	} res_t;

endpackage

FILE: design/mnlc_core.sv
module mnlc_core import mnlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item,
	input  cfg_t        cfg,
	input  logic        init_load,
	input  logic [15:0] init_value,
	output grp_t        grp
);

	logic        have_core_q, core_pending_q;
	logic [47:0] core_addr_q, pend_addr_q;
	logic [7:0]  range_start_q, range_end_q, version_q;
	logic [31:0] beat_q, last_req_q, last_beat_q, last_scan_q, seen_q, fwd_q;
	logic [15:0] req_int_q;

	logic        have_nx, pending_nx;
	logic [47:0] core_nx, pend_nx;
	logic [7:0]  start_nx, end_nx, version_nx;
	logic [31:0] beat_nx, last_req_nx, last_beat_nx, last_scan_nx, seen_nx, fwd_nx;
	logic [15:0] req_int_nx;

	logic        adopt, req_fire, hb_fire, scan_fire, match;
	logic [16:0] twice;
	logic [1:0]  n;
	action_t [2:0] acts;

	always_comb begin
		match = 1'b0;
		for (int j = 0; j < MATCH_ENTRIES; j++) begin
			if (8'(j) >= range_start_q && 8'(j) <= range_end_q &&
			    CHAN_TABLE[j] == item.scan_ch)
				match = 1'b1;
		end
	end

	always_comb begin
		have_nx      = have_core_q;
		pending_nx   = core_pending_q;
		core_nx      = core_addr_q;
		pend_nx      = pend_addr_q;
		start_nx     = range_start_q;
		end_nx       = range_end_q;
		version_nx   = version_q;
		beat_nx      = beat_q;
		last_req_nx  = last_req_q;
		last_beat_nx = last_beat_q;
		last_scan_nx = last_scan_q;
		seen_nx      = seen_q;
		fwd_nx       = fwd_q;
		req_int_nx   = req_int_q;
		adopt        = 1'b0;
		req_fire     = 1'b0;
		hb_fire      = 1'b0;
		scan_fire    = 1'b0;
		twice        = {req_int_q, 1'b0};
		acts         = {3{ACT_IDLE}};
		n            = 2'd1;
		unique case (item.op)
			OP_TICK: begin
				adopt = core_pending_q;
				if (adopt) begin
					pending_nx = 1'b0;
					core_nx    = pend_addr_q;
					have_nx    = 1'b1;
					req_int_nx = cfg.req_init;
				end
				req_fire  = !have_nx && (item.now_ms - last_req_q) >= 32'(req_int_q);
				hb_fire   = have_nx && (item.now_ms - last_beat_q) >= 32'(cfg.hb_period);
				scan_fire = have_nx && (item.now_ms - last_scan_q) >= 32'(cfg.scan_period);
				if (req_fire) begin
					last_req_nx = item.now_ms;
					req_int_nx  = (twice > 17'(cfg.req_max)) ? cfg.req_max : twice[15:0];
				end
				if (hb_fire) begin
					last_beat_nx = item.now_ms;
					beat_nx      = beat_q + 32'd1;
				end
				if (scan_fire)
					last_scan_nx = item.now_ms;
				n = 2'd0;
				if (adopt) begin
					acts[n] = ACT_ADOPT;
					n       = n + 2'd1;
				end
				if (req_fire) begin
					acts[n] = ACT_REQUEST;
					n       = n + 2'd1;
				end
				if (hb_fire) begin
					acts[n] = ACT_HEARTBEAT;
					n       = n + 2'd1;
				end
				if (scan_fire) begin
					acts[n] = ACT_SCAN_START;
					n       = n + 2'd1;
				end
				if (n == 2'd0)
					n = 2'd1;
			end
			OP_FRAME: begin
				acts[0] = ACT_IGNORED;
				if (item.len >= MIN_FRAME_LEN && item.magic == FRAME_MAGIC) begin
					if (item.frame_type == TYPE_CORE_REPLY && !have_core_q &&
					    !core_pending_q) begin
						pend_nx    = item.src_mac;
						pending_nx = 1'b1;
						acts[0]    = ACT_LATCHED;
					end else if (item.frame_type == TYPE_ADMIN && item.len >= ADMIN_LEN) begin
						if (item.version == version_q) begin
							acts[0] = ACT_UNCHANGED;
						end else begin
							version_nx = item.version;
							start_nx   = item.start_idx;
							end_nx     = item.end_idx;
							acts[0]    = ACT_ASSIGNED;
						end
					end
				end
			end
			OP_SCAN: begin
				seen_nx = seen_q + 32'd1;
				acts[0] = ACT_FILTERED;
				if (match) begin
					fwd_nx  = fwd_q + 32'd1;
					acts[0] = ACT_FORWARD;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		grp.cnt      = n;
		grp.act      = acts;
		grp.dest_mac = have_nx ? core_nx : BROADCAST_MAC;
		grp.linked   = have_nx;
		grp.beat_old = beat_q;
		grp.beat_new = beat_nx;
		grp.found    = seen_nx;
		grp.sent     = fwd_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_core_q    <= 1'b0;
			core_pending_q <= 1'b0;
			core_addr_q    <= '0;
			pend_addr_q    <= '0;
			range_start_q  <= '0;
			range_end_q    <= RANGE_END_RST;
			version_q      <= '0;
			beat_q         <= '0;
			last_req_q     <= '0;
			last_beat_q    <= '0;
			last_scan_q    <= '0;
			seen_q         <= '0;
			fwd_q          <= '0;
			req_int_q      <= REQ_INIT_RST;
		end else if (init_load) begin
			req_int_q <= init_value;
		end else if (fire) begin
			have_core_q    <= have_nx;
			core_pending_q <= pending_nx;
			core_addr_q    <= core_nx;
			pend_addr_q    <= pend_nx;
			range_start_q  <= start_nx;
			range_end_q    <= end_nx;
			version_q      <= version_nx;
			beat_q         <= beat_nx;
			last_req_q     <= last_req_nx;
			last_beat_q    <= last_beat_nx;
			last_scan_q    <= last_scan_nx;
			seen_q         <= seen_nx;
			fwd_q          <= fwd_nx;
			req_int_q      <= req_int_nx;
		end
	end

endmodule

FILE: design/mnlc_outq.sv
module mnlc_outq import mnlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t grp_in,
	output logic full,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	grp_t       grp_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q, idx_q;
	grp_t       head;
	action_t    cur_act;
	logic       pop, take;

	assign head      = grp_q[rd_ptr_q];
	assign full      = cnt_q == 2'd2;
	assign res_valid = cnt_q != 2'd0;
	assign cur_act   = head.act[idx_q];
	assign take      = res_valid && !res_stall;
	assign pop       = take && res.last;

	always_comb begin
		res.action   = cur_act;
		res.dest_mac = head.dest_mac;
		res.beat     = (cur_act == ACT_ADOPT) ? head.beat_old : head.beat_new;
		res.linked   = head.linked;
		res.found    = head.found;
		res.sent     = head.sent;
		res.last     = idx_q == head.cnt - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (push)
			grp_q[wr_ptr_q] <= grp_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: design/mesh_node_link_controller_top.sv
// channel   handshake              payload
// input     in_valid / in_stall    op, now_ms, rx_*, scan_channel
// output    out_valid / out_stall  action, dest_mac, heartbeat_count, linked,
//                                  found_total, sent_total, last_result
// config    cfg_we                 cfg_index, cfg_wdata
//
// An item waits in the input register while the queue is full, then is
// evaluated and its group of 1..3 results is registered in the result queue.
// Results leave one per cycle while out_stall is low.
// Input stalls only while the input register holds an item and the two-group
// result queue is full; out_stall backs up through the queue.
// Asynchronous reset sets control state and config; payloads are not reset.
module mesh_node_link_controller_top import mnlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] now_ms,
	input  logic [7:0]  rx_len,
	input  logic [31:0] rx_magic,
	input  logic [7:0]  rx_type,
	input  logic [47:0] rx_src_mac,
	input  logic [7:0]  rx_assign_version,
	input  logic [7:0]  rx_start_idx,
	input  logic [7:0]  rx_end_idx,
	input  logic [7:0]  scan_channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  action,
	output logic [47:0] dest_mac,
	output logic [31:0] heartbeat_count,
	output logic        linked,
	output logic [31:0] found_total,
	output logic [31:0] sent_total,
	output logic        last_result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	item_t item_s1;
	logic  valid_s1;
	cfg_t  cfg_q;
	logic  q_full, fire, in_take, init_load;
	grp_t  grp;
	res_t  res;

	assign fire      = valid_s1 && !q_full;
	assign in_stall  = valid_s1 && q_full;
	assign in_take   = in_valid && !in_stall;
	assign init_load = cfg_we && cfg_index == REG_REQ_INIT;

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op         <= op;
			item_s1.now_ms     <= now_ms;
			item_s1.len        <= rx_len;
			item_s1.magic      <= rx_magic;
			item_s1.frame_type <= rx_type;
			item_s1.src_mac    <= rx_src_mac;
			item_s1.version    <= rx_assign_version;
			item_s1.start_idx  <= rx_start_idx;
			item_s1.end_idx    <= rx_end_idx;
			item_s1.scan_ch    <= scan_channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			cfg_q.req_init    <= REQ_INIT_RST;
			cfg_q.req_max     <= REQ_MAX_RST;
			cfg_q.hb_period   <= HB_PERIOD_RST;
			cfg_q.scan_period <= SCAN_PERIOD_RST;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					REG_REQ_INIT:    cfg_q.req_init    <= cfg_wdata;
					REG_REQ_MAX:     cfg_q.req_max     <= cfg_wdata;
					REG_HB_PERIOD:   cfg_q.hb_period   <= cfg_wdata;
					REG_SCAN_PERIOD: cfg_q.scan_period <= cfg_wdata;
				endcase
			end
		end
	end

	mnlc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.cfg        (cfg_q),
		.init_load  (init_load),
		.init_value (cfg_wdata),
		.grp        (grp)
	);

	mnlc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.grp_in    (grp),
		.full      (q_full),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (res)
	);

	assign action          = res.action;
	assign dest_mac        = res.dest_mac;
	assign heartbeat_count = res.beat;
	assign linked          = res.linked;
	assign found_total     = res.found;
	assign sent_total      = res.sent;
	assign last_result     = res.last;

`ifndef NO_ASSERTIONS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> out_valid)
		else $error("result group cut short");

	a_link_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && linked |-> dest_mac != BROADCAST_MAC || res.action != ACT_REQUEST)
		else $error("core request sent while linked");
`endif

endmodule

FILE: tb/mesh_link_monitor.sv
module mesh_link_monitor import mnlc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] now_ms,
	input  logic [7:0]  rx_len,
	input  logic [31:0] rx_magic,
	input  logic [7:0]  rx_type,
	input  logic [47:0] rx_src_mac,
	input  logic [7:0]  rx_assign_version,
	input  logic [7:0]  rx_start_idx,
	input  logic [7:0]  rx_end_idx,
	input  logic [7:0]  scan_channel,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  action,
	input  logic [47:0] dest_mac,
	input  logic [31:0] heartbeat_count,
	input  logic        linked,
	input  logic [31:0] found_total,
	input  logic [31:0] sent_total,
	input  logic        last_result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int unsigned mismatches,
	output int unsigned awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CHANNELS     = 40;
	localparam logic [47:0] ALL_STATIONS = '1;
	localparam logic [31:0] MAGIC_WORD   = "ENOW";
	localparam logic [7:0]  SHORTEST     = 8'd5;
	localparam logic [7:0]  ADMIN_SHORTEST = 8'd10;

	localparam logic [7:0] CHANNEL_PLAN [CHANNELS] = '{
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
		8'd13, 8'd14, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd60, 8'd64,
		8'd100, 8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd132, 8'd136, 8'd140,
		8'd144, 8'd149, 8'd153, 8'd157, 8'd161, 8'd165, 8'd169, 8'd173, 8'd177
	};

	logic        have_core, core_pending;
	logic [47:0] core_mac, pending_mac;
	logic [7:0]  first_idx, last_idx, range_version;
	logic [31:0] beats, last_request, request_gap, last_beat, last_scan;
	logic [31:0] seen, forwarded;
	logic [15:0] init_gap, max_gap, beat_period, scan_period;

	res_t        expected_q[$];
	res_t        batch[3];
	res_t        want;
	item_t       taken;
	int unsigned errors = 0;

	function automatic res_t snapshot(input action_t act);
		res_t r;
		r.action   = act;
		r.dest_mac = have_core ? core_mac : ALL_STATIONS;
		r.beat     = beats;
		r.linked   = have_core;
		r.found    = seen;
		r.sent     = forwarded;
		r.last     = 1'b0;
		return r;
	endfunction

	task automatic predict_results(input item_t it);
		int          n;
		int          j;
		logic [31:0] elapsed;
		logic [31:0] doubled;
		logic        hit;
		action_t     verdict;
		n = 0;
		case (it.op)
		OP_TICK: begin
			if (core_pending) begin
				core_pending = 1'b0;
				core_mac     = pending_mac;
				have_core    = 1'b1;
				request_gap  = {16'd0, init_gap};
				batch[n]     = snapshot(ACT_ADOPT);
				n++;
			end
			elapsed = it.now_ms - last_request;
			if (!have_core && elapsed >= request_gap) begin
				doubled      = request_gap << 1;
				last_request = it.now_ms;
				request_gap  = (doubled > {16'd0, max_gap}) ? {16'd0, max_gap} : doubled;
				batch[n]     = snapshot(ACT_REQUEST);
				n++;
			end
			elapsed = it.now_ms - last_beat;
			if (have_core && elapsed >= {16'd0, beat_period}) begin
				last_beat = it.now_ms;
				beats++;
				batch[n] = snapshot(ACT_HEARTBEAT);
				n++;
			end
			elapsed = it.now_ms - last_scan;
			if (have_core && elapsed >= {16'd0, scan_period}) begin
				last_scan = it.now_ms;
				batch[n]  = snapshot(ACT_SCAN_START);
				n++;
			end
			if (n == 0) begin
				batch[0] = snapshot(ACT_IDLE);
				n = 1;
			end
		end
		OP_FRAME: begin
			if (it.len < SHORTEST || it.magic != MAGIC_WORD) begin
				verdict = ACT_IGNORED;
			end else if (it.frame_type == TYPE_CORE_REPLY && !have_core && !core_pending) begin
				pending_mac  = it.src_mac;
				core_pending = 1'b1;
				verdict      = ACT_LATCHED;
			end else if (it.frame_type == TYPE_ADMIN && it.len >= ADMIN_SHORTEST) begin
				if (it.version == range_version) begin
					verdict = ACT_UNCHANGED;
				end else begin
					range_version = it.version;
					first_idx     = it.start_idx;
					last_idx      = it.end_idx;
					verdict       = ACT_ASSIGNED;
				end
			end else begin
				verdict = ACT_IGNORED;
			end
			batch[0] = snapshot(verdict);
			n = 1;
		end
		OP_SCAN: begin
			seen++;
			hit = 1'b0;
			for (j = first_idx; j <= last_idx && j < CHANNELS; j++)
				if (CHANNEL_PLAN[j] == it.scan_ch)
					hit = 1'b1;
			if (hit)
				forwarded++;
			batch[0] = snapshot(hit ? ACT_FORWARD : ACT_FILTERED);
			n = 1;
		end
		default: begin
			batch[0] = snapshot(ACT_IDLE);
			n = 1;
		end
		endcase
		batch[n - 1].last = 1'b1;
		for (j = 0; j < n; j++)
			expected_q.push_back(batch[j]);
	endtask

	function automatic void check_field(input string name, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_gap      = 16'd300;
			max_gap       = 16'd5000;
			beat_period   = 16'd5000;
			scan_period   = 16'd4500;
			have_core     = 1'b0;
			core_pending  = 1'b0;
			core_mac      = '0;
			pending_mac   = '0;
			first_idx     = 8'd0;
			last_idx      = 8'(CHANNELS - 1);
			range_version = 8'd0;
			beats         = '0;
			last_request  = '0;
			request_gap   = {16'd0, init_gap};
			last_beat     = '0;
			last_scan     = '0;
			seen          = '0;
			forwarded     = '0;
			expected_q.delete();
			mismatches   <= 0;
			awaited      <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result with no transaction waiting, action %0d", action);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("action", want.action, action);
					check_field("dest_mac", want.dest_mac, dest_mac);
					check_field("heartbeat_count", want.beat, heartbeat_count);
					check_field("linked", want.linked, linked);
					check_field("found_total", want.found, found_total);
					check_field("sent_total", want.sent, sent_total);
					check_field("last_result", want.last, last_result);
				end
			end
			if (in_valid && !in_stall) begin
				taken.op         = op;
				taken.now_ms     = now_ms;
				taken.len        = rx_len;
				taken.magic      = rx_magic;
				taken.frame_type = rx_type;
				taken.src_mac    = rx_src_mac;
				taken.version    = rx_assign_version;
				taken.start_idx  = rx_start_idx;
				taken.end_idx    = rx_end_idx;
				taken.scan_ch    = scan_channel;
				predict_results(taken);
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
				REG_REQ_INIT: begin
					init_gap    = cfg_wdata;
					request_gap = {16'd0, cfg_wdata};
				end
				REG_REQ_MAX:     max_gap = cfg_wdata;
				REG_HB_PERIOD:   beat_period = cfg_wdata;
				REG_SCAN_PERIOD: scan_period = cfg_wdata;
				endcase
			end
			mismatches <= errors;
			awaited    <= expected_q.size();
		end
	end

endmodule

FILE: tb/tb_mesh_node_link_controller_top.sv
module tb_mesh_node_link_controller_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mnlc_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200_000;
	localparam int          HOLD_CYCLES  = 80;
	localparam logic [1:0]  OP_UNKNOWN   = 2'd3;

	typedef enum {FLOW, LIGHT, HEAVY, ALTERNATE, HOLD} stall_style_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [31:0] now_ms;
	logic [7:0]  rx_len;
	logic [31:0] rx_magic;
	logic [7:0]  rx_type;
	logic [47:0] rx_src_mac;
	logic [7:0]  rx_assign_version;
	logic [7:0]  rx_start_idx;
	logic [7:0]  rx_end_idx;
	logic [7:0]  scan_channel;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  action;
	logic [47:0] dest_mac;
	logic [31:0] heartbeat_count;
	logic        linked;
	logic [31:0] found_total;
	logic [31:0] sent_total;
	logic        last_result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	int unsigned mismatches;
	int unsigned awaited;

	logic [31:0] clock_ms = '0;
	int          burst_left = 0;
	bit          squeeze_req = 1'b0;
	bit          squeezed = 1'b0;
	int unsigned cycle_count = 0;

	mesh_node_link_controller_top DUT (.*);
	mesh_link_monitor monitor (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: stretches of different stall styles, one long hold on request
	initial begin : receiver
		stall_style_t style;
		int           stretch;
		int           k;
		out_stall <= 1'b0;
		forever begin
			if (squeeze_req && !squeezed) begin
				style    = HOLD;
				stretch  = HOLD_CYCLES;
				squeezed = 1'b1;
			end else begin
				style   = stall_style_t'($urandom_range(0, 3));
				stretch = $urandom_range(4, 30);
			end
			for (k = 0; k < stretch; k++) begin
				@(posedge clk);
				case (style)
				FLOW:      out_stall <= 1'b0;
				LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
				HEAVY:     out_stall <= ($urandom_range(0, 3) != 0);
				ALTERNATE: out_stall <= k[0];
				default:   out_stall <= 1'b1;
				endcase
			end
		end
	end

	function automatic item_t noise_item();
		item_t it;
		it.op         = OP_TICK;
		it.now_ms     = $urandom();
		it.len        = 8'($urandom());
		it.magic      = $urandom();
		it.frame_type = 8'($urandom());
		it.src_mac    = {16'($urandom()), $urandom()};
		it.version    = 8'($urandom());
		it.start_idx  = 8'($urandom());
		it.end_idx    = 8'($urandom());
		it.scan_ch    = 8'($urandom());
		return it;
	endfunction

	function automatic item_t tick_item(input logic [31:0] now);
		item_t it;
		it        = noise_item();
		it.now_ms = now;
		return it;
	endfunction

	function automatic item_t frame_item(input logic [7:0] len, input logic [31:0] magic,
		input logic [7:0] kind);
		item_t it;
		it            = noise_item();
		it.op         = OP_FRAME;
		it.len        = len;
		it.magic      = magic;
		it.frame_type = kind;
		return it;
	endfunction

	function automatic item_t admin_item(input logic [7:0] len, input logic [7:0] ver,
		input logic [7:0] first, input logic [7:0] last);
		item_t it;
		it           = frame_item(len, FRAME_MAGIC, TYPE_ADMIN);
		it.version   = ver;
		it.start_idx = first;
		it.end_idx   = last;
		return it;
	endfunction

	function automatic item_t scan_item(input logic [7:0] ch);
		item_t it;
		it         = noise_item();
		it.op      = OP_SCAN;
		it.scan_ch = ch;
		return it;
	endfunction

	function automatic item_t random_item(input bit link_ok, input int unsigned stride);
		item_t       it;
		int unsigned pick;
		it   = noise_item();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if ($urandom_range(0, 15) == 0)
				clock_ms = $urandom();
			else
				clock_ms += $urandom_range(0, stride);
			it.now_ms = clock_ms;
		end else if (pick < 70) begin
			it.op    = OP_FRAME;
			it.magic = FRAME_MAGIC;
			it.len   = 8'($urandom_range(ADMIN_MIN_LEN, 255));
			pick     = $urandom_range(0, 9);
			if (pick < 2 && link_ok) begin
				it.frame_type = TYPE_CORE_REPLY;
			end else if (pick < 8) begin
				it.frame_type = TYPE_ADMIN;
				if ($urandom_range(0, 1))
					it.version = 8'($urandom_range(0, 3));
				if ($urandom_range(0, 3) != 0) begin
					it.start_idx = 8'($urandom_range(0, 39));
					it.end_idx   = 8'($urandom_range(it.start_idx, 39));
				end
			end else if (!link_ok && it.frame_type == TYPE_CORE_REPLY) begin
				it.frame_type = ~TYPE_CORE_REPLY;
			end
			case ($urandom_range(0, 4))
			0:       it.len = 8'($urandom_range(0, MIN_FRAME_LEN - 1));
			1:       it.magic = FRAME_MAGIC ^ (32'd1 << $urandom_range(0, 31));
			2:       it.len = 8'($urandom_range(MIN_FRAME_LEN, ADMIN_LEN - 1));
			default: ;
			endcase
		end else if (pick < 95) begin
			it.op = OP_SCAN;
			if ($urandom_range(0, 4) < 3)
				it.scan_ch = CHAN_TABLE[$urandom_range(0, DEFINED_ENTRIES - 1)];
		end else begin
			it.op = OP_UNKNOWN;
		end
		return it;
	endfunction

	task automatic offer(input item_t it);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
				: $urandom_range(1, 5);
		end
		in_valid          <= 1'b1;
		op                <= it.op;
		now_ms            <= it.now_ms;
		rx_len            <= it.len;
		rx_magic          <= it.magic;
		rx_type           <= it.frame_type;
		rx_src_mac        <= it.src_mac;
		rx_assign_version <= it.version;
		rx_start_idx      <= it.start_idx;
		rx_end_idx        <= it.end_idx;
		scan_channel      <= it.scan_ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic random_run(input int count, input bit link_ok, input int unsigned stride);
		repeat (count)
			offer(random_item(link_ok, stride));
	endtask

	// called right at the edge of the last transaction
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] first_gap, cap, beat, scan_gap);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_REQ_INIT;
		cfg_wdata <= first_gap;
		@(posedge clk);
		cfg_index <= REG_REQ_MAX;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_index <= REG_HB_PERIOD;
		cfg_wdata <= beat;
		@(posedge clk);
		cfg_index <= REG_SCAN_PERIOD;
		cfg_wdata <= scan_gap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_valid          <= 1'b0;
		op                <= OP_TICK;
		now_ms            <= '0;
		rx_len            <= '0;
		rx_magic          <= '0;
		rx_type           <= '0;
		rx_src_mac        <= '0;
		rx_assign_version <= '0;
		rx_start_idx      <= '0;
		rx_end_idx        <= '0;
		scan_channel      <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_REQ_INIT;
		cfg_wdata         <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, not linked
		offer(tick_item(32'd0));
		offer(tick_item(32'd299));
		offer(tick_item(32'd300));
		offer(tick_item(32'd900));
		offer(frame_item(8'd0, FRAME_MAGIC, TYPE_ADMIN) | {OP_UNKNOWN, 160'd0});
		offer(frame_item(MIN_FRAME_LEN - 1, FRAME_MAGIC, TYPE_ADMIN));
		offer(frame_item(MIN_FRAME_LEN, FRAME_MAGIC ^ 32'd1, TYPE_CORE_REPLY));
		offer(frame_item(8'd255, FRAME_MAGIC, 8'hFF));
		offer(admin_item(ADMIN_LEN - 1, 8'd1, 8'd0, 8'd5));
		offer(admin_item(ADMIN_LEN, 8'd0, 8'd0, 8'd5));
		offer(scan_item(8'd1));
		offer(scan_item(8'd177));
		offer(scan_item(8'd0));
		offer(scan_item(8'd255));
		offer(admin_item(8'd255, 8'd1, 8'd38, 8'd255));
		offer(scan_item(8'd177));
		offer(scan_item(8'd1));
		offer(admin_item(ADMIN_LEN, 8'd255, 8'd20, 8'd10));
		offer(scan_item(8'd60));
		offer(tick_item(32'hFFFF_FFFF));
		offer(tick_item(32'd2398));
		offer(tick_item(32'd2399));
		offer(admin_item(ADMIN_LEN, 8'hAA, 8'd0, 8'd39));
		clock_ms = 32'd2399;

		reconfigure(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_run(20, 1'b0, 40000);
		reconfigure(16'hFFFF, 16'd1, 16'd1, 16'd1);
		random_run(10, 1'b0, 70000);
		reconfigure(16'd0, 16'd0, 16'd0, 16'd0);
		random_run(12, 1'b0, 100);

		// link up: second reply while one is pending, adopt on the tick
		reconfigure(16'd300, 16'd5000, 16'd0, 16'd0);
		offer(frame_item(ADMIN_LEN, FRAME_MAGIC, TYPE_CORE_REPLY));
		offer(frame_item(ADMIN_LEN, FRAME_MAGIC, TYPE_CORE_REPLY));
		offer(tick_item(clock_ms));
		offer(frame_item(MIN_FRAME_LEN, FRAME_MAGIC, TYPE_CORE_REPLY));
		random_run(15, 1'b1, 50);

		reconfigure(16'd2, 16'hFFFF, 16'd1, 16'hFFFF);
		random_run(14, 1'b1, 70000);
		reconfigure(16'd300, 16'd5000, 16'd5000, 16'd4500);
		squeeze_req = 1'b1;
		random_run(30, 1'b1, 6000);
		settle();

		if (mismatches == 0 && awaited == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
